@@ hdl/arae_pkg.sv @@
// Shared types and constants for the ARM relocation addend extractor.
// No dependencies; used by arae_decode, the top level and the checker.

package arae_pkg;

    localparam int CLASS_W  = 4;
    localparam int INSTR_W  = 32;
    localparam int ADDEND_W = 33;
    // addend padded up to whole bytes on the result stream
    localparam int OUT_TDATA_W = ((ADDEND_W + 7) / 8) * 8;

    // ADR subtract form: bits 9:5 of the first halfword
    localparam logic [4:0] THM_ADR_SUB_OP = 5'h15;
    // ARM data-processing SUB opcode, bits 24:21
    localparam logic [3:0] ARM_OP_SUB = 4'h2;

    typedef enum logic [CLASS_W-1:0] {
        CLS_ALU_PC       = 4'd0,
        CLS_LDR          = 4'd1,
        CLS_LDRS         = 4'd2,
        CLS_LDC          = 4'd3,
        CLS_BRANCH24     = 4'd4,
        CLS_MOVW         = 4'd5,
        CLS_MOVT         = 4'd6,
        CLS_THM_MOVW     = 4'd7,
        CLS_THM_MOVT     = 4'd8,
        CLS_JUMP19       = 4'd9,
        CLS_THM_ADR      = 4'd10,
        CLS_THM_BRANCH24 = 4'd11,
        CLS_PC12         = 4'd12,
        CLS_THM_ALU_ABS  = 4'd13
    } reloc_class_t;

    typedef struct packed {
        logic [ADDEND_W-1:0] addend;
        logic                supported;
    } result_t;

endpackage

@@ hdl/arm_reloc_addend_extract.sv @@
// Top level of the ARM relocation implicit addend extractor: stream ports,
// input register, decode, result register. Depends on arae_pkg, arae_decode.
//
// Path: input register, decode, result register; throughput: one item per
// cycle while m_tready holds.
// Rate is set by the single decode stage between the two registers.
// Reset (rst_n low, asynchronous) empties both stages and sets be_mode to 0.

module arm_reloc_addend_extract
(
    input  logic                              clk,
    input  logic                              rst_n,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [arae_pkg::INSTR_W-1:0]      s_tdata,   // [31:0] instr_bytes
    input  logic [arae_pkg::CLASS_W-1:0]      s_tuser,   // [3:0] reloc_class
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [arae_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [32:0] addend, [39:33] zero
    output logic                              m_tuser,   // [0] supported
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data   // [0] be_mode
);

    // configuration: always ready; to be written only while the pipe is empty
    logic be_mode_reg;

    // input stage
    logic                         in_valid_reg;
    logic [arae_pkg::INSTR_W-1:0] in_instr_reg;
    logic [arae_pkg::CLASS_W-1:0] in_class_reg;

    // result stage
    logic              out_valid_reg;
    arae_pkg::result_t out_result_reg;
    arae_pkg::result_t dec_result;

    logic out_ready;

    // Ready chains back through both stages so a full pipe still advances
    // every cycle while the result side takes transfers.
    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            be_mode_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            be_mode_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_instr_reg <= s_tdata;
            in_class_reg <= s_tuser;
        end
        if (in_valid_reg && out_ready)
        begin
            out_result_reg <= dec_result;
        end
    end

    arae_decode u_decode
    (
        .reloc_class (in_class_reg),
        .instr_bytes (in_instr_reg),
        .be_mode     (be_mode_reg),
        .result      (dec_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(arae_pkg::OUT_TDATA_W - arae_pkg::ADDEND_W){1'b0}},
                       out_result_reg.addend};
    assign m_tuser  = out_result_reg.supported;

endmodule

@@ hdl/arae_decode.sv @@
// Combinational addend decode for one instruction and relocation class.
// Depends on arae_pkg.

module arae_decode
(
    input  logic [arae_pkg::CLASS_W-1:0] reloc_class,
    input  logic [arae_pkg::INSTR_W-1:0] instr_bytes,
    input  logic                         be_mode,
    output arae_pkg::result_t            result
);

    function automatic logic [arae_pkg::ADDEND_W-1:0] neg_if(
        input logic                          neg,
        input logic [arae_pkg::ADDEND_W-1:0] v
    );
        return neg ? (~v + 1'b1) : v;
    endfunction

    logic [31:0] word;
    logic [15:0] h1;
    logic [15:0] h2;

    always_comb
    begin
        if (be_mode)
        begin
            word = {instr_bytes[7:0], instr_bytes[15:8], instr_bytes[23:16], instr_bytes[31:24]};
            h1   = {instr_bytes[7:0], instr_bytes[15:8]};
            h2   = {instr_bytes[23:16], instr_bytes[31:24]};
        end
        else
        begin
            word = instr_bytes;
            h1   = instr_bytes[15:0];
            h2   = instr_bytes[31:16];
        end
    end

    always_comb
    begin
        arae_pkg::reloc_class_t cls;
        logic [63:0] rot_dbl;
        logic [31:0] rot_val;
        logic [15:0] thm_imm16;
        logic        s;
        logic        j1;
        logic        j2;
        logic        ubit;

        cls       = arae_pkg::reloc_class_t'(reloc_class);
        rot_dbl   = {24'd0, word[7:0], 24'd0, word[7:0]} >> {word[11:8], 1'b0};
        rot_val   = rot_dbl[31:0];
        thm_imm16 = {h1[3:0], h1[10], h2[14:12], h2[7:0]};
        s         = h1[10];
        j1        = h2[13];
        j2        = h2[11];
        ubit      = word[23];

        result.supported = 1'b1;
        unique case (cls)
            arae_pkg::CLS_ALU_PC:
                result.addend = neg_if(word[24:21] == arae_pkg::ARM_OP_SUB, {1'b0, rot_val});
            arae_pkg::CLS_LDR:
                result.addend = neg_if(!ubit, {21'd0, word[11:0]});
            arae_pkg::CLS_LDRS:
                result.addend = neg_if(!ubit, {25'd0, word[11:8], word[3:0]});
            arae_pkg::CLS_LDC:
                result.addend = neg_if(!ubit, {23'd0, word[7:0], 2'b00});
            arae_pkg::CLS_BRANCH24:
                result.addend = {{7{word[23]}}, word[23:0], 2'b00};
            arae_pkg::CLS_MOVW:
                result.addend = {{17{word[19]}}, word[19:16], word[11:0]};
            arae_pkg::CLS_MOVT:
                result.addend = {17'd0, word[19:16], word[11:0]};
            arae_pkg::CLS_THM_MOVW:
                result.addend = {17'd0, thm_imm16};
            arae_pkg::CLS_THM_MOVT:
                result.addend = {thm_imm16[15], thm_imm16, 16'd0};
            arae_pkg::CLS_JUMP19:
                result.addend = {{12{s}}, s, j2, j1, h1[5:0], h2[10:0], 1'b0};
            arae_pkg::CLS_THM_ADR:
                result.addend = neg_if(h1[9:5] == arae_pkg::THM_ADR_SUB_OP, {25'd0, h2[7:0]});
            arae_pkg::CLS_THM_BRANCH24:
                result.addend = {{8{s}}, s, ~(j1 ^ s), ~(j2 ^ s), h1[9:0], h2[10:0], 1'b0};
            arae_pkg::CLS_PC12:
                result.addend = neg_if(!h1[7], {21'd0, h2[11:0]});
            arae_pkg::CLS_THM_ALU_ABS:
                result.addend = {25'd0, h1[7:0]};
            default:
            begin
                result.addend    = '0;
                result.supported = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/arae_checker.sv @@
// Port-level checks for arm_reloc_addend_extract, attached by bind.
// Depends on arae_pkg.

module arae_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [arae_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input logic                              m_tuser
);

    // stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // unsupported class yields a zero addend
    a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("unsupported class with non-zero addend");

    // byte padding above the addend is zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[arae_pkg::OUT_TDATA_W-1:arae_pkg::ADDEND_W] == '0)
        else $error("padding bits set");

    // an accepted item reaches the output through both registers unless m_tready holds it up
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
        else $error("result missing after accepted item");

endmodule

bind arm_reloc_addend_extract arae_checker u_arae_checker (.*);

@@ verif/arm_reloc_addend_extract_tb.sv @@
// Self-checking testbench for arm_reloc_addend_extract: predicts the decoded addend of
// every input transfer and compares it against the result stream.
// Depends on arae_pkg and the arm_reloc_addend_extract RTL.

module arm_reloc_addend_extract_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam time CLK_PERIOD      = 10ns;
    localparam int  RESET_CYCLES    = 5;
    localparam int  PRESSURE_AT     = 500;     // accepted transfers before the long hold-off
    localparam int  PRESSURE_CYCLES = 150;
    localparam int  DRAIN_CYCLES    = 20;      // idle wait after the final drain
    localparam int  LIMIT_CYCLES    = 600_000; // watchdog limit on simulation length
    localparam int  REPORT_MAX      = 40;

    // class codes outside the decoded set
    localparam logic [arae_pkg::CLASS_W-1:0] CLS_UNSUP_A = 4'd14;
    localparam logic [arae_pkg::CLASS_W-1:0] CLS_UNSUP_B = 4'd15;

    typedef struct {
        logic [arae_pkg::CLASS_W-1:0] cls;
        logic [arae_pkg::INSTR_W-1:0] bytes;
    } instr_item_t;

    typedef struct {
        arae_pkg::result_t            want;
        logic [arae_pkg::CLASS_W-1:0] cls;
        logic [arae_pkg::INSTR_W-1:0] bytes;
    } addend_due_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             s_tvalid  = 1'b0;
    logic                             s_tready;
    logic [arae_pkg::INSTR_W-1:0]     s_tdata   = '0;   // [31:0] instr_bytes
    logic [arae_pkg::CLASS_W-1:0]     s_tuser   = '0;   // [3:0] reloc_class
    logic                             m_tvalid;
    logic                             m_tready  = 1'b0;
    logic [arae_pkg::OUT_TDATA_W-1:0] m_tdata;          // [32:0] addend, [39:33] zero
    logic                             m_tuser;          // [0] supported
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic                             cfg_data  = 1'b0; // [0] be_mode

    instr_item_t pending[$];      // items waiting for the driver
    addend_due_t addend_due[$];   // predicted results, oldest first
    instr_item_t next_item;

    bit be_mode_shadow = 1'b0;    // our copy of the byte-order register
    bit steady         = 1'b0;    // when set, neither side idles
    bit sink_hold      = 1'b0;    // long receiver hold-off
    int send_gap       = 0;
    int sink_stall     = 0;
    int accepted_cnt   = 0;
    int mismatch_cnt   = 0;

    arm_reloc_addend_extract dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic [31:0] swap_bytes(logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [arae_pkg::ADDEND_W-1:0] negate_when(
        bit                            neg,
        logic [arae_pkg::ADDEND_W-1:0] v
    );
        return neg ? -v : v;
    endfunction

    // Decode one instruction under the given byte order.
    function automatic arae_pkg::result_t decode_addend(logic [arae_pkg::CLASS_W-1:0] cls,
                                                        logic [arae_pkg::INSTR_W-1:0] raw,
                                                        bit be);
        arae_pkg::result_t r;
        logic [31:0] word;
        logic [31:0] imm8;
        logic [63:0] rot2;
        logic [15:0] h1, h2, v16;
        logic        s, i1, i2;
        word = be ? swap_bytes(raw) : raw;
        // big-endian halfwords sit in word order, little-endian ones swapped
        h1 = be ? word[31:16] : word[15:0];
        h2 = be ? word[15:0]  : word[31:16];
        s  = h1[10];
        r.supported = 1'b1;
        r.addend    = '0;
        unique case (cls)
            arae_pkg::CLS_ALU_PC:
            begin
                // rotate right by twice the rotation field via a doubled copy
                imm8 = {24'h0, word[7:0]};
                rot2 = {imm8, imm8} >> {word[11:8], 1'b0};
                r.addend = negate_when(word[24:21] == arae_pkg::ARM_OP_SUB,
                                       {1'b0, rot2[31:0]});
            end
            arae_pkg::CLS_LDR:
                r.addend = negate_when(!word[23], {21'h0, word[11:0]});
            arae_pkg::CLS_LDRS:
                r.addend = negate_when(!word[23], {25'h0, word[11:8], word[3:0]});
            arae_pkg::CLS_LDC:
                r.addend = negate_when(!word[23], {23'h0, word[7:0], 2'b00});
            arae_pkg::CLS_BRANCH24:
                r.addend = {{7{word[23]}}, word[23:0], 2'b00};
            arae_pkg::CLS_MOVW:
            begin
                v16 = {word[19:16], word[11:0]};
                r.addend = {{17{v16[15]}}, v16};
            end
            arae_pkg::CLS_MOVT:
                r.addend = {17'h0, word[19:16], word[11:0]};
            arae_pkg::CLS_THM_MOVW:
                r.addend = {17'h0, h1[3:0], h1[10], h2[14:12], h2[7:0]};
            arae_pkg::CLS_THM_MOVT:
            begin
                v16 = {h1[3:0], h1[10], h2[14:12], h2[7:0]};
                r.addend = {v16[15], v16, 16'h0};
            end
            arae_pkg::CLS_JUMP19:
                r.addend = {{12{s}}, s, h2[11], h2[13], h1[5:0], h2[10:0], 1'b0};
            arae_pkg::CLS_THM_ADR:
                r.addend = negate_when(h1[9:5] == arae_pkg::THM_ADR_SUB_OP,
                                       {25'h0, h2[7:0]});
            arae_pkg::CLS_THM_BRANCH24:
            begin
                i1 = ~(h2[13] ^ s);
                i2 = ~(h2[11] ^ s);
                r.addend = {{8{s}}, s, i1, i2, h1[9:0], h2[10:0], 1'b0};
            end
            arae_pkg::CLS_PC12:
                r.addend = negate_when(!h1[7], {21'h0, h2[11:0]});
            arae_pkg::CLS_THM_ALU_ABS:
                r.addend = {25'h0, h1[7:0]};
            default:
                r.supported = 1'b0;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one; none in steady stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Push random bytes towards the negated forms and the zero rotation,
    // which uniform bytes hit only rarely.
    function automatic logic [31:0] steer_fields(logic [arae_pkg::CLASS_W-1:0] cls,
                                                 logic [arae_pkg::INSTR_W-1:0] raw,
                                                 bit be);
        logic [31:0] word;
        logic [15:0] h1, h2;
        word = be ? swap_bytes(raw) : raw;
        h1   = be ? word[31:16] : word[15:0];
        h2   = be ? word[15:0]  : word[31:16];
        unique case (cls)
            arae_pkg::CLS_ALU_PC:
            begin
                if ($urandom_range(0, 2) == 0)
                    word[24:21] = arae_pkg::ARM_OP_SUB;
                if ($urandom_range(0, 3) == 0)
                    word[11:8] = 4'h0;
            end
            arae_pkg::CLS_THM_ADR:
                if ($urandom_range(0, 1) == 0)
                begin
                    h1[9:5] = arae_pkg::THM_ADR_SUB_OP;
                    word = be ? {h1, h2} : {h2, h1};
                end
            default:
                ;
        endcase
        return be ? swap_bytes(word) : word;
    endfunction

    task automatic queue_instr(logic [arae_pkg::CLASS_W-1:0] cls,
                               logic [arae_pkg::INSTR_W-1:0] bytes);
        instr_item_t it;
        it.cls   = cls;
        it.bytes = bytes;
        pending.push_back(it);
    endtask

    task automatic queue_random(int count);
        logic [arae_pkg::CLASS_W-1:0] cls;
        int unsigned                  pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 15);
            cls  = pick[arae_pkg::CLASS_W-1:0];
            queue_instr(cls, steer_fields(cls, $urandom, be_mode_shadow));
        end
    endtask

    // Wait until the driver is empty and every predicted result has arrived.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending.size() != 0 || s_tvalid || addend_due.size() != 0);
    endtask

    // One transfer on the configuration channel; only called while idle.
    task automatic write_byte_order(bit be);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= be;
        do
            @(posedge clk);
        while (!cfg_ready);
        be_mode_shadow = be;
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_MAX)
            $display("%0t MISMATCH %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items on the input stream. An item's addend
    // is predicted at the edge where its transfer completes.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                addend_due.push_back('{decode_addend(s_tuser, s_tdata, be_mode_shadow),
                                       s_tuser, s_tdata});
                accepted_cnt++;
            end
            // the slot is free unless an offered item is still waiting
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    next_item = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.bytes;
                    s_tuser  <= next_item.cls;
                    send_gap <= pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest prediction
    // and throttles m_tready.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            sink_stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (addend_due.size() == 0)
                    report_mismatch($sformatf("result with nothing outstanding: addend %h",
                                              m_tdata[arae_pkg::ADDEND_W-1:0]));
                else
                begin
                    automatic addend_due_t due = addend_due.pop_front();
                    if (m_tdata[arae_pkg::ADDEND_W-1:0] !== due.want.addend)
                        report_mismatch($sformatf("addend class %0d bytes %h: got %h want %h",
                                                  due.cls, due.bytes,
                                                  m_tdata[arae_pkg::ADDEND_W-1:0],
                                                  due.want.addend));
                    if (m_tuser !== due.want.supported)
                        report_mismatch($sformatf("supported class %0d: got %b want %b",
                                                  due.cls, m_tuser, due.want.supported));
                    if (m_tdata[arae_pkg::OUT_TDATA_W-1:arae_pkg::ADDEND_W] !== '0)
                        report_mismatch($sformatf("tdata padding not zero: %h", m_tdata));
                end
            end
            if (sink_hold)
                m_tready <= 1'b0;
            else if (sink_stall != 0)
            begin
                sink_stall <= sink_stall - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    sink_stall <= pick_gap();
            end
        end
    end

    // Long receiver hold-off mid-run so the pipeline fills and s_tready drops.
    initial
    begin
        while (accepted_cnt < PRESSURE_AT)
            @(posedge clk);
        sink_hold <= 1'b1;
        repeat (PRESSURE_CYCLES) @(posedge clk);
        sink_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed set at the reset byte order, then random
    // phases alternating the byte order.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, little-endian: every class with all bits set, then the
        // corner forms. Words below are in little-endian memory order.
        for (int c = 0; c < 16; c++)
            queue_instr(c[arae_pkg::CLASS_W-1:0], 32'hFFFF_FFFF);
        queue_instr(arae_pkg::CLS_ALU_PC,      32'h0000_0000);
        queue_instr(arae_pkg::CLS_ALU_PC,      32'h0040_0081); // SUB, rotation field zero
        queue_instr(arae_pkg::CLS_ALU_PC,      32'h0040_0F81); // SUB, rotate by 30
        queue_instr(arae_pkg::CLS_LDR,         32'h0080_0FFF); // U set, largest offset
        queue_instr(arae_pkg::CLS_BRANCH24,    32'h007F_FFFF); // largest forward branch
        queue_instr(arae_pkg::CLS_THM_ADR,     32'h00FF_02A0); // subtract form of ADR
        queue_instr(arae_pkg::CLS_PC12,        32'h0FFF_0080); // add form of PC12
        queue_instr(arae_pkg::CLS_THM_ALU_ABS, 32'hFFFF_0000); // upper bytes must be ignored
        queue_instr(CLS_UNSUP_A,               32'h0000_0000);
        queue_instr(CLS_UNSUP_B,               32'h8000_0001);
        wait_drained();

        write_byte_order(1'b1);
        queue_random(300);
        wait_drained();

        write_byte_order(1'b0);
        queue_random(400);   // receiver hold-off lands in this phase
        wait_drained();

        // back-to-back transfers with no idling on either side
        write_byte_order(1'b1);
        steady = 1'b1;
        queue_random(150);
        wait_drained();
        steady = 1'b0;

        write_byte_order(1'b0);
        queue_random(250);
        wait_drained();

        // nothing further may appear on the result stream
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && addend_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/arae_pkg.sv
hdl/arae_decode.sv
hdl/arm_reloc_addend_extract.sv
hdl/arae_checker.sv
verif/arm_reloc_addend_extract_tb.sv
